FILE: rtl/core/pat_packet_generator_macros.svh
// ---------------------------------------------------------------------------
// PAT packet generator assertion macros
// Shared concurrent assertion forms for the packet generator modules.
// ---------------------------------------------------------------------------
`ifndef PAT_PACKET_GENERATOR_MACROS_SVH
`define PAT_PACKET_GENERATOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PAT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("PAT generator same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define PAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("PAT generator next-cycle check failed");

`endif

FILE: rtl/core/pat_pkg.sv
// ---------------------------------------------------------------------------
// PAT packet generator package
// Types, packet constants and the byte and CRC functions of the generator.
// ---------------------------------------------------------------------------
package pat_pkg;

    localparam int PKT_WORDS   = 47;
    localparam int SEC_FIRST   = 5;
    localparam int SEC_BYTES   = 12;
    localparam int WIDX_W      = 6;
    localparam int SCNT_W      = 4;
    localparam int BIDX_W      = 8;

    localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(PKT_WORDS - 1);
    localparam logic [SCNT_W-1:0] SEC_DONE  = SCNT_W'(SEC_BYTES);

    localparam logic [31:0] CRC_POLY = 32'h04c1_1db7;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

    localparam logic [7:0] SYNC_BYTE    = 8'h47;
    localparam logic [7:0] PUSI_BYTE    = 8'h40;
    localparam logic [3:0] AFC_PAYLOAD  = 4'h1;
    localparam logic [7:0] PAT_TABLE_ID = 8'h00;
    localparam logic [7:0] SEC_FLAGS    = 8'hb0;
    localparam logic [7:0] SEC_LENGTH   = 8'(SEC_BYTES + 1);
    localparam logic [1:0] VER_RSVD     = 2'b11;
    localparam logic [2:0] PID_RSVD     = 3'b111;
    localparam logic [7:0] STUFF_BYTE   = 8'hff;

    typedef struct packed {
        logic [15:0] stream_id;
        logic [4:0]  version_number;
        logic        current_next;
        logic [15:0] program_number;
        logic [12:0] pmt_pid;
    } req_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {data, 24'h0};
        for (int b = 0; b < 8; b++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] pkt_byte(input logic [BIDX_W-1:0] idx, input req_t r,
                                            input logic [3:0] cc, input logic [31:0] crc);
        logic [7:0] v;
        case (idx)
            8'd0:    v = SYNC_BYTE;
            8'd1:    v = PUSI_BYTE;
            8'd2:    v = 8'h00;
            8'd3:    v = {AFC_PAYLOAD, cc};
            8'd4:    v = 8'h00;
            8'd5:    v = PAT_TABLE_ID;
            8'd6:    v = SEC_FLAGS;
            8'd7:    v = SEC_LENGTH;
            8'd8:    v = r.stream_id[15:8];
            8'd9:    v = r.stream_id[7:0];
            8'd10:   v = {VER_RSVD, r.version_number, r.current_next};
            8'd11:   v = 8'h00;
            8'd12:   v = 8'h00;
            8'd13:   v = r.program_number[15:8];
            8'd14:   v = r.program_number[7:0];
            8'd15:   v = {PID_RSVD, r.pmt_pid[12:8]};
            8'd16:   v = r.pmt_pid[7:0];
            8'd17:   v = crc[31:24];
            8'd18:   v = crc[23:16];
            8'd19:   v = crc[15:8];
            8'd20:   v = crc[7:0];
            default: v = STUFF_BYTE;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/pat_req_if.sv
// ---------------------------------------------------------------------------
// PAT request channel
// Valid/ready channel that carries one packet request.
// ---------------------------------------------------------------------------
interface pat_req_if;

    logic        valid;
    logic        ready;
    logic [15:0] stream_id;
    logic [4:0]  version_number;
    logic        current_next;
    logic [15:0] program_number;
    logic [12:0] pmt_pid;

    modport source (
        output valid, stream_id, version_number, current_next, program_number, pmt_pid,
        input  ready
    );

    modport sink (
        input  valid, stream_id, version_number, current_next, program_number, pmt_pid,
        output ready
    );

endinterface

FILE: rtl/core/pat_word_if.sv
// ---------------------------------------------------------------------------
// PAT packet word channel
// Valid/ready channel that carries one 32-bit packet word.
// ---------------------------------------------------------------------------
interface pat_word_if;

    logic        valid;
    logic        ready;
    logic [31:0] packet_word;
    logic [5:0]  word_index;
    logic        last_word;

    modport source (
        output valid, packet_word, word_index, last_word,
        input  ready
    );

    modport sink (
        input  valid, packet_word, word_index, last_word,
        output ready
    );

endinterface

FILE: rtl/core/pat_packet_generator.sv
// ---------------------------------------------------------------------------
// PAT packet generator
// Builds one 188-byte transport stream packet with a single-program PAT and
// its CRC-32 for each request, and sends it as 47 big-endian words.
//
// Channel   Direction  Payload
// req       in         stream_id, version_number, current_next, program_number, pmt_pid
// word      out        packet_word, word_index, last_word
//
// A packet is sent as 47 words on the output, one word per transfer.
// The section CRC is computed one byte per cycle, over its 12 bytes, while the
// previous packet is still being sent, so packets follow back to back.
// A request with a zero PMT PID is taken and dropped without output.
// Output stalls hold the current word; reset clears the continuity counter.
// ---------------------------------------------------------------------------
`include "pat_packet_generator_macros.svh"

module pat_packet_generator (
    input  logic clk,
    input  logic rst_n,
    pat_req_if.sink    req,
    pat_word_if.source word
);

    import pat_pkg::*;

    logic              cc_reg;
    logic [3:0]        cc_cnt_reg;
    logic              a_full_reg;
    logic [SCNT_W-1:0] a_cnt_reg;
    req_t              a_req_reg;
    logic [3:0]        a_cc_reg;
    logic [31:0]       a_crc_reg;

    logic              b_active_reg;
    logic [WIDX_W-1:0] b_idx_reg;
    req_t              b_req_reg;
    logic [3:0]        b_cc_reg;
    logic [31:0]       b_crc_reg;

    logic              in_xfer;
    logic              in_take;
    logic              out_xfer;
    logic              out_last;
    logic              a_done;
    logic              b_load;
    logic [3:0]        cc_next;
    logic [BIDX_W-1:0] sec_idx;
    logic [BIDX_W-1:0] byte_base;
    req_t              in_req;

    assign in_req.stream_id      = req.stream_id;
    assign in_req.version_number = req.version_number;
    assign in_req.current_next   = req.current_next;
    assign in_req.program_number = req.program_number;
    assign in_req.pmt_pid        = req.pmt_pid;

    assign req.ready = !a_full_reg;
    assign in_xfer   = req.valid && req.ready;
    assign in_take   = in_xfer && (req.pmt_pid != 13'd0);
    assign cc_next   = cc_cnt_reg + 4'd1;

    assign a_done   = a_full_reg && (a_cnt_reg == SEC_DONE);
    assign out_last = (b_idx_reg == LAST_WIDX);
    assign out_xfer = b_active_reg && word.ready;
    assign b_load   = a_done && (!b_active_reg || (out_xfer && out_last));
    assign sec_idx  = BIDX_W'(SEC_FIRST) + BIDX_W'(a_cnt_reg);

    // The continuity counter advances once per packet that is built.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg     <= 1'b0;
            cc_cnt_reg <= 4'd0;
        end
        else if (in_take)
        begin
            cc_reg     <= 1'b1;
            cc_cnt_reg <= cc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_full_reg <= 1'b0;
            a_cnt_reg  <= '0;
        end
        else if (in_take)
        begin
            a_full_reg <= 1'b1;
            a_cnt_reg  <= '0;
        end
        else if (b_load)
        begin
            a_full_reg <= 1'b0;
        end
        else if (a_full_reg && !a_done)
        begin
            a_cnt_reg <= a_cnt_reg + SCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_req_reg <= in_req;
            a_cc_reg  <= cc_next;
            a_crc_reg <= CRC_INIT;
        end
        else if (a_full_reg && !a_done)
        begin
            a_crc_reg <= crc_byte(a_crc_reg, pkt_byte(sec_idx, a_req_reg, a_cc_reg, a_crc_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_active_reg <= 1'b0;
            b_idx_reg    <= '0;
        end
        else if (b_load)
        begin
            b_active_reg <= 1'b1;
            b_idx_reg    <= '0;
        end
        else if (out_xfer)
        begin
            if (out_last)
            begin
                b_active_reg <= 1'b0;
            end
            else
            begin
                b_idx_reg <= b_idx_reg + WIDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_req_reg <= a_req_reg;
            b_cc_reg  <= a_cc_reg;
            b_crc_reg <= a_crc_reg;
        end
    end

    assign byte_base = {b_idx_reg, 2'b00};

    assign word.valid       = b_active_reg;
    assign word.word_index  = b_idx_reg;
    assign word.last_word   = out_last;
    assign word.packet_word = {
        pkt_byte(byte_base,                 b_req_reg, b_cc_reg, b_crc_reg),
        pkt_byte(byte_base + BIDX_W'(1),    b_req_reg, b_cc_reg, b_crc_reg),
        pkt_byte(byte_base + BIDX_W'(2),    b_req_reg, b_cc_reg, b_crc_reg),
        pkt_byte(byte_base + BIDX_W'(3),    b_req_reg, b_cc_reg, b_crc_reg)
    };

    `PAT_ASSERT_NEXT(a_start_chk, clk, rst_n, in_take, a_full_reg && (a_cnt_reg == '0))
    `PAT_ASSERT_SAME(a_cnt_chk, clk, rst_n, a_full_reg, a_cnt_reg <= SEC_DONE)
    `PAT_ASSERT_SAME(b_idx_chk, clk, rst_n, b_active_reg, b_idx_reg <= LAST_WIDX)
    `PAT_ASSERT_NEXT(b_step_chk, clk, rst_n, out_xfer && !out_last,
                     b_active_reg && (b_idx_reg == $past(b_idx_reg) + WIDX_W'(1)))
    `PAT_ASSERT_NEXT(cc_step_chk, clk, rst_n, in_take && cc_reg,
                     cc_cnt_reg == $past(cc_cnt_reg) + 4'd1)

endmodule
